// ===== design/ring_fifo_with_overwrite_defines.svh =====
`ifndef RING_FIFO_WITH_OVERWRITE_DEFINES_SVH
`define RING_FIFO_WITH_OVERWRITE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFO_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RFO_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== design/rfo_pkg.sv =====
package rfo_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ENTRY_BITS_DEF = 32;

	localparam int MODE_W   = 2;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd1;

	localparam logic [CFG_W-1:0] CAPACITY_RST = 5'd16;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   read_data;
		logic [STATUS_W-1:0] result_status;
		logic [COUNT_W-1:0]  entry_count;
		logic                is_empty;
	} rsp_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic                empty;
		logic                rd_ok;
	} res_t;

endpackage

// ===== design/rfo_mem.sv =====
module rfo_mem
	import rfo_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ENTRY_BITS = ENTRY_BITS_DEF,
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  logic [ENTRY_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr,
	output logic [ENTRY_BITS-1:0] rdata
);

	logic [ENTRY_BITS-1:0] mem_q [DEPTH];
	logic [ENTRY_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rfo_ctrl.sv =====
module rfo_ctrl
	import rfo_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 acc,
	input  logic [MODE_W-1:0]    mode,
	output logic                 mem_we,
	output logic [IDX_W-1:0]     mem_waddr,
	output logic                 mem_re,
	output logic [IDX_W-1:0]     mem_raddr,
	output res_t                 res
);

	logic             overwrite_q;
	logic [CFG_W-1:0] capacity_q;
	logic [IDX_W-1:0] wi_q, wi_d;
	logic [IDX_W-1:0] ri_q, ri_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] cap;
	logic             full;

	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] n;
		n = CNT_W'(i) + 1'b1;
		return (n >= c) ? '0 : IDX_W'(n);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overwrite_q <= 1'b0;
			capacity_q  <= CAPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OVERWRITE: overwrite_q <= cfg_data[0];
				REG_CAPACITY:  capacity_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp capacity to 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap = CNT_W'(1);
		end else if (32'(capacity_q) > 32'(DEPTH)) begin
			cap = CNT_W'(DEPTH);
		end else begin
			cap = CNT_W'(capacity_q);
		end
	end

	assign full = cnt_q >= cap;

	always_comb begin
		wi_d       = wi_q;
		ri_d       = ri_q;
		cnt_d      = cnt_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		res.status = ST_OK;
		res.rd_ok  = 1'b0;
		case (mode)
			MODE_WRITE: begin
				if (full && !overwrite_q) begin
					res.status = ST_FULL;
				end else begin
					mem_we = acc;
					wi_d   = adv(wi_q, cap);
					if (full) begin
						ri_d = adv(ri_q, cap);
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			MODE_READ: begin
				if (cnt_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					mem_re    = acc;
					res.rd_ok = 1'b1;
					ri_d      = adv(ri_q, cap);
					cnt_d     = cnt_q - 1'b1;
				end
			end
			MODE_FLUSH: begin
				wi_d  = '0;
				ri_d  = '0;
				cnt_d = '0;
			end
			default: ;
		endcase
		res.count = COUNT_W'(cnt_d);
		res.empty = (cnt_d == '0);
	end

	assign mem_waddr = wi_q;
	assign mem_raddr = ri_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q  <= '0;
			ri_q  <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			wi_q  <= wi_d;
			ri_q  <= ri_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== design/ring_fifo_with_overwrite.sv =====
// result: a registered result appears in the cycle after its request is taken
// throughput: one request per cycle while the result side keeps up; each request
//   does at most one access to the entry memory in its accept cycle
// reset: indices, count and output valid clear at once, overwrite mode turns off
//   and capacity returns to its full default; entry memory is not cleared
`include "ring_fifo_with_overwrite_defines.svh"

module ring_fifo_with_overwrite
	import rfo_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  acc;
	logic                  mem_we;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_waddr;
	logic [IDX_W-1:0]      mem_raddr;
	logic [ENTRY_BITS-1:0] mem_wdata;
	logic [ENTRY_BITS-1:0] mem_rdata;
	res_t                  res;
	logic                  rsp_valid_q;
	res_t                  res_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign mem_wdata = ENTRY_BITS'(64'(req.write_data));

	rfo_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.mode      (req.mode),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	rfo_mem #(
		.DEPTH      (DEPTH),
		.ENTRY_BITS (ENTRY_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_ready) begin
			rsp_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp.read_data     = res_q.rd_ok ? DATA_W'(64'(mem_rdata)) : '0;
	assign rsp.result_status = res_q.status;
	assign rsp.entry_count   = res_q.count;
	assign rsp.is_empty      = res_q.empty;

	// memory is touched only by a taken request
	`RFO_ASSERT_NOW(a_mem_on_accept, mem_we || mem_re, acc, "memory access without accept")
	// a rejected write shows up as the next result beat
	`RFO_ASSERT_NEXT(a_full_reported, acc && res.status == ST_FULL,
		rsp_valid && rsp.result_status == ST_FULL, "full status lost")
	// only a successful read returns data
	`RFO_ASSERT_NOW(a_no_data_on_error, rsp_valid && rsp.result_status != ST_OK,
		rsp.read_data == '0, "data on failed beat")

endmodule
